FILE: design/pfr_pkg.sv
package pfr_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W = 32;
	localparam int CYC_W = 48;
	localparam int PEN_W = 16;
	localparam int QDEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_PENALTY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRITEBACK_PENALTY = 3'd4;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU = 1'b1;

	localparam logic [4:0] RST_FRAMES_IN_USE = 5'd16;
	localparam logic [4:0] RST_PAGE_SHIFT = 5'd12;
	localparam logic [PEN_W-1:0] RST_LOAD_PENALTY = 16'd100;
	localparam logic [PEN_W-1:0] RST_WRITEBACK_PENALTY = 16'd500;

	typedef struct packed {
		logic policy_mode;
		logic [4:0] frames_in_use;
		logic [4:0] page_shift;
		logic [PEN_W-1:0] load_penalty;
		logic [PEN_W-1:0] writeback_penalty;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic evicted;
		logic evicted_dirty;
	} res_t;

endpackage

FILE: design/pfr_front.sv
module pfr_front #(
	parameter int PAGE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] address,
	input logic is_write,
	input logic [4:0] page_shift,
	input logic q_full,
	output logic q_push,
	output logic [PAGE_BITS-1:0] q_page,
	output logic q_wr
);
	import pfr_pkg::*;

	logic v_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic wr_s1;
	logic [31:0] shifted;
	logic take;

	assign shifted = address >> page_shift;
	assign busy = v_s1 && q_full;
	assign take = start && !busy;
	assign q_push = v_s1 && !q_full;
	assign q_page = page_s1;
	assign q_wr = wr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			page_s1 <= shifted[PAGE_BITS-1:0];
			wr_s1 <= is_write;
		end
	end

endmodule

FILE: design/pfr_fifo.sv
module pfr_fifo #(
	parameter int W = 25
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	input logic pop,
	output logic [W-1:0] rdata,
	output logic full,
	output logic empty
);
	import pfr_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [W-1:0] mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: design/pfr_table.sv
module pfr_table #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input pfr_pkg::cfg_t cfg,
	input logic pop,
	input logic [PAGE_BITS-1:0] in_page,
	input logic in_wr,
	output pfr_pkg::res_t res,
	output logic [PAGE_BITS-1:0] evp
);
	import pfr_pkg::*;

	localparam int IW = $clog2(MAX_FRAMES);
	localparam int FW = $clog2(MAX_FRAMES + 1);
	localparam int LW = (FW > 5) ? FW : 5;
	localparam logic [LW-1:0] MAXL = LW'(MAX_FRAMES);

	logic [PAGE_BITS-1:0] page_q [MAX_FRAMES];
	logic [IW-1:0] rank_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [MAX_FRAMES-1:0] dirty_q;
	logic [FW-1:0] occ_q;
	res_t res_s3;
	logic [PAGE_BITS-1:0] evp_s3;

	logic [MAX_FRAMES-1:0] match;
	logic hit;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] hit_rank;
	logic [IW-1:0] old_idx;
	logic [LW-1:0] fr_w;
	logic [LW-1:0] lim;
	logic fill;
	logic evict;
	logic [IW-1:0] occ_idx;
	logic [IW-1:0] newest_rank;
	logic lru;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		hit_rank = '0;
		old_idx = '0;
		for (int f = 0; f < MAX_FRAMES; f++) begin
			match[f] = valid_q[f] && (page_q[f] == in_page);
			if (match[f]) begin
				hit = 1'b1;
				hit_idx = hit_idx | IW'(f);
				hit_rank = hit_rank | rank_q[f];
			end
			if (valid_q[f] && (rank_q[f] == '0)) begin
				old_idx = old_idx | IW'(f);
			end
		end
	end

	always_comb begin
		fr_w = LW'(cfg.frames_in_use);
		priority if (fr_w == '0) begin
			lim = LW'(1);
		end else if (fr_w > MAXL) begin
			lim = MAXL;
		end else begin
			lim = fr_w;
		end
	end

	assign fill = !hit && (LW'(occ_q) < lim);
	assign evict = !hit && !fill;
	assign occ_idx = occ_q[IW-1:0];
	assign newest_rank = IW'(occ_q - 1'b1);
	assign lru = (cfg.policy_mode == POLICY_LRU);
	assign res = res_s3;
	assign evp = evp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			occ_q <= '0;
			res_s3 <= '0;
		end else begin
			res_s3.valid <= pop;
			if (pop) begin
				res_s3.hit <= hit;
				res_s3.evicted <= evict;
				res_s3.evicted_dirty <= evict && dirty_q[old_idx];
				if (hit) begin
					if (in_wr) begin
						dirty_q[hit_idx] <= 1'b1;
					end
				end else if (fill) begin
					valid_q[occ_idx] <= 1'b1;
					dirty_q[occ_idx] <= in_wr;
					occ_q <= occ_q + 1'b1;
				end else begin
					dirty_q[old_idx] <= in_wr;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			evp_s3 <= evict ? page_q[old_idx] : '0;
			if (hit) begin
				if (lru) begin
					for (int f = 0; f < MAX_FRAMES; f++) begin
						if (valid_q[f] && (rank_q[f] > hit_rank)) begin
							rank_q[f] <= rank_q[f] - 1'b1;
						end
					end
					rank_q[hit_idx] <= newest_rank;
				end
			end else if (fill) begin
				page_q[occ_idx] <= in_page;
				rank_q[occ_idx] <= occ_idx;
			end else begin
				for (int f = 0; f < MAX_FRAMES; f++) begin
					if (valid_q[f] && (rank_q[f] != '0)) begin
						rank_q[f] <= rank_q[f] - 1'b1;
					end
				end
				rank_q[old_idx] <= newest_rank;
				page_q[old_idx] <= in_page;
			end
		end
	end

	a_unique_page: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> $onehot0(match))
		else $error("page resident in more than one frame");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && fill |=> occ_q == FW'($past(occ_q) + 1'b1))
		else $error("occupancy did not grow on a fill");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(occ_q) <= MAXL)
		else $error("occupancy beyond frame count");

	a_evict_needs_frames: assert property (@(posedge clk) disable iff (!arst_n)
		pop && evict |-> occ_q != '0)
		else $error("eviction from an empty table");

endmodule

FILE: design/pfr_stats.sv
module pfr_stats #(
	parameter int PAGE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input pfr_pkg::cfg_t cfg,
	input pfr_pkg::res_t res,
	input logic [PAGE_BITS-1:0] evp,
	output logic done,
	output logic hit,
	output logic evicted,
	output logic evicted_dirty,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [pfr_pkg::CNT_W-1:0] hit_count,
	output logic [pfr_pkg::CNT_W-1:0] fault_count,
	output logic [pfr_pkg::CNT_W-1:0] reference_count,
	output logic [pfr_pkg::CYC_W-1:0] total_cycles
);
	import pfr_pkg::*;

	logic done_q;
	logic hit_q;
	logic ev_q;
	logic evd_q;
	logic [PAGE_BITS-1:0] evp_q;
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] faults_q;
	logic [CNT_W-1:0] refs_q;
	logic [CYC_W-1:0] cyc_q;
	logic [PEN_W:0] delta;
	logic [CYC_W:0] cyc_sum;

	assign delta = {1'b0, cfg.load_penalty}
		+ (res.evicted_dirty ? {1'b0, cfg.writeback_penalty} : '0);
	assign cyc_sum = {1'b0, cyc_q} + (CYC_W + 1)'(delta);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hits_q <= '0;
			faults_q <= '0;
			refs_q <= '0;
			cyc_q <= '0;
		end else begin
			done_q <= res.valid;
			if (res.valid) begin
				if (&refs_q == 1'b0) begin
					refs_q <= refs_q + 1'b1;
				end
				if (res.hit) begin
					if (&hits_q == 1'b0) begin
						hits_q <= hits_q + 1'b1;
					end
				end else begin
					if (&faults_q == 1'b0) begin
						faults_q <= faults_q + 1'b1;
					end
					cyc_q <= cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			hit_q <= res.hit;
			ev_q <= res.evicted;
			evd_q <= res.evicted_dirty;
			evp_q <= evp;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign evicted = ev_q;
	assign evicted_dirty = evd_q;
	assign evicted_page = evp_q;
	assign hit_count = hits_q;
	assign fault_count = faults_q;
	assign reference_count = refs_q;
	assign total_cycles = cyc_q;

endmodule

FILE: design/page_frame_replacement_unit.sv
// Channel   Handshake                  Payload
// request   start, busy                address, is_write
// result    done (one-cycle strobe)    hit, evicted, evicted_dirty, evicted_page, counts
// config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// A request can be taken every cycle while busy is low; the table does the frame lookup and age update.
// The result strobe follows the front register, the queue, the table result register and the stats register.
// Reset empties the frame table, clears occupancy and counters and sets the default configuration at once.
// The receiver cannot stall; busy rises only when the front register and queue are full.
module page_frame_replacement_unit #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] address,
	input logic is_write,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic done,
	output logic hit,
	output logic evicted,
	output logic evicted_dirty,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [pfr_pkg::CNT_W-1:0] hit_count,
	output logic [pfr_pkg::CNT_W-1:0] fault_count,
	output logic [pfr_pkg::CNT_W-1:0] reference_count,
	output logic [pfr_pkg::CYC_W-1:0] total_cycles
);
	import pfr_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic [PAGE_BITS-1:0] q_page;
	logic q_wr;
	logic [PAGE_BITS:0] q_rdata;
	res_t res;
	logic [PAGE_BITS-1:0] evp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy_mode <= POLICY_FIFO;
			cfg_q.frames_in_use <= RST_FRAMES_IN_USE;
			cfg_q.page_shift <= RST_PAGE_SHIFT;
			cfg_q.load_penalty <= RST_LOAD_PENALTY;
			cfg_q.writeback_penalty <= RST_WRITEBACK_PENALTY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLICY_MODE: cfg_q.policy_mode <= cfg_data[0];
				REG_FRAMES_IN_USE: cfg_q.frames_in_use <= cfg_data[4:0];
				REG_PAGE_SHIFT: cfg_q.page_shift <= cfg_data[4:0];
				REG_LOAD_PENALTY: cfg_q.load_penalty <= cfg_data;
				REG_WRITEBACK_PENALTY: cfg_q.writeback_penalty <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pfr_front #(
		.PAGE_BITS(PAGE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.address(address),
		.is_write(is_write),
		.page_shift(cfg_q.page_shift),
		.q_full(q_full),
		.q_push(q_push),
		.q_page(q_page),
		.q_wr(q_wr)
	);

	pfr_fifo #(
		.W(PAGE_BITS + 1)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata({q_wr, q_page}),
		.pop(!q_empty),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	pfr_table #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop(!q_empty),
		.in_page(q_rdata[PAGE_BITS-1:0]),
		.in_wr(q_rdata[PAGE_BITS]),
		.res(res),
		.evp(evp)
	);

	pfr_stats #(
		.PAGE_BITS(PAGE_BITS)
	) u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.res(res),
		.evp(evp),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.evicted_dirty(evicted_dirty),
		.evicted_page(evicted_page),
		.hit_count(hit_count),
		.fault_count(fault_count),
		.reference_count(reference_count),
		.total_cycles(total_cycles)
	);

endmodule

FILE: test/pfr_checker.sv
`timescale 1ns / 1ps
module pfr_checker #(
	parameter int MAX_FRAMES = 16,
	parameter int PAGE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [31:0] address,
	input logic is_write,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic done,
	input logic hit,
	input logic evicted,
	input logic evicted_dirty,
	input logic [PAGE_BITS-1:0] evicted_page,
	input logic [pfr_pkg::CNT_W-1:0] hit_count,
	input logic [pfr_pkg::CNT_W-1:0] fault_count,
	input logic [pfr_pkg::CNT_W-1:0] reference_count,
	input logic [pfr_pkg::CYC_W-1:0] total_cycles,
	output int mismatches,
	output int pending,
	output int results_checked,
	output int hits_checked,
	output int evictions_checked,
	output int dirty_checked
);

	typedef struct packed {
		logic hit;
		logic evicted;
		logic evicted_dirty;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [pfr_pkg::CNT_W-1:0] hit_count;
		logic [pfr_pkg::CNT_W-1:0] fault_count;
		logic [pfr_pkg::CNT_W-1:0] reference_count;
		logic [pfr_pkg::CYC_W-1:0] total_cycles;
	} access_outcome_t;

	logic lru_mode;
	logic [4:0] frame_limit_cfg;
	logic [4:0] shift_cfg;
	logic [pfr_pkg::PEN_W-1:0] load_pen;
	logic [pfr_pkg::PEN_W-1:0] wb_pen;

	logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
	logic frame_used [MAX_FRAMES];
	logic frame_modified [MAX_FRAMES];
	int unsigned age_rank [MAX_FRAMES];
	int unsigned occupied;
	logic [pfr_pkg::CNT_W-1:0] hits_acc;
	logic [pfr_pkg::CNT_W-1:0] faults_acc;
	logic [pfr_pkg::CNT_W-1:0] refs_acc;
	logic [pfr_pkg::CYC_W-1:0] cycles_acc;

	access_outcome_t outcome_q [$];

	function automatic logic [pfr_pkg::CYC_W-1:0] add_cycles(
		input logic [pfr_pkg::CYC_W-1:0] acc,
		input logic [pfr_pkg::PEN_W-1:0] delta
	);
		logic [pfr_pkg::CYC_W:0] sum;
		sum = {1'b0, acc} + delta;
		return sum[pfr_pkg::CYC_W] ? '1 : sum[pfr_pkg::CYC_W-1:0];
	endfunction

	task automatic promote(input int unsigned pos);
		int unsigned moved;
		int unsigned i;
		moved = age_rank[pos];
		for (i = pos; i + 1 < occupied; i++)
			age_rank[i] = age_rank[i + 1];
		age_rank[occupied - 1] = moved;
	endtask

	task automatic resolve_access(
		input logic [31:0] addr,
		input logic wr,
		output access_outcome_t res
	);
		int unsigned limit;
		int unsigned pos;
		int unsigned slot;
		int unsigned i;
		logic [PAGE_BITS-1:0] pg;
		logic found;
		res = '0;
		limit = (frame_limit_cfg == 0) ? 1 :
			((frame_limit_cfg > MAX_FRAMES) ? MAX_FRAMES : frame_limit_cfg);
		pg = PAGE_BITS'(addr >> shift_cfg);
		found = 1'b0;
		pos = 0;
		for (i = 0; i < occupied; i++) begin
			if (frame_used[age_rank[i]] && frame_page[age_rank[i]] == pg) begin
				found = 1'b1;
				pos = i;
			end
		end
		if (found) begin
			slot = age_rank[pos];
			if (wr)
				frame_modified[slot] = 1'b1;
			if (lru_mode == pfr_pkg::POLICY_LRU)
				promote(pos);
			if (hits_acc != '1)
				hits_acc++;
			res.hit = 1'b1;
		end else begin
			if (occupied < limit) begin
				slot = occupied;
				age_rank[occupied] = slot;
				occupied++;
			end else begin
				slot = age_rank[0];
				res.evicted = 1'b1;
				res.evicted_dirty = frame_modified[slot];
				res.evicted_page = frame_page[slot];
				if (frame_modified[slot])
					cycles_acc = add_cycles(cycles_acc, wb_pen);
				promote(0);
			end
			frame_page[slot] = pg;
			frame_used[slot] = 1'b1;
			frame_modified[slot] = wr;
			if (faults_acc != '1)
				faults_acc++;
			cycles_acc = add_cycles(cycles_acc, load_pen);
		end
		if (refs_acc != '1)
			refs_acc++;
		res.hit_count = hits_acc;
		res.fault_count = faults_acc;
		res.reference_count = refs_acc;
		res.total_cycles = cycles_acc;
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		access_outcome_t want;
		int unsigned i;
		if (!arst_n) begin
			lru_mode = pfr_pkg::POLICY_FIFO;
			frame_limit_cfg = pfr_pkg::RST_FRAMES_IN_USE;
			shift_cfg = pfr_pkg::RST_PAGE_SHIFT;
			load_pen = pfr_pkg::RST_LOAD_PENALTY;
			wb_pen = pfr_pkg::RST_WRITEBACK_PENALTY;
			for (i = 0; i < MAX_FRAMES; i++) begin
				frame_page[i] = '0;
				frame_used[i] = 1'b0;
				frame_modified[i] = 1'b0;
				age_rank[i] = 0;
			end
			occupied = 0;
			hits_acc = '0;
			faults_acc = '0;
			refs_acc = '0;
			cycles_acc = '0;
			outcome_q.delete();
			mismatches = 0;
			pending = 0;
			results_checked = 0;
			hits_checked = 0;
			evictions_checked = 0;
			dirty_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pfr_pkg::REG_POLICY_MODE: lru_mode = cfg_data[0];
					pfr_pkg::REG_FRAMES_IN_USE: frame_limit_cfg = cfg_data[4:0];
					pfr_pkg::REG_PAGE_SHIFT: shift_cfg = cfg_data[4:0];
					pfr_pkg::REG_LOAD_PENALTY: load_pen = cfg_data;
					pfr_pkg::REG_WRITEBACK_PENALTY: wb_pen = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("Result strobe seen with no request outstanding.");
					mismatches++;
				end else begin
					want = outcome_q[0];
					outcome_q.delete(0);
					check_field("hit", want.hit, hit);
					check_field("evicted", want.evicted, evicted);
					check_field("evicted_dirty", want.evicted_dirty, evicted_dirty);
					check_field("evicted_page", want.evicted_page, evicted_page);
					check_field("hit_count", want.hit_count, hit_count);
					check_field("fault_count", want.fault_count, fault_count);
					check_field("reference_count", want.reference_count, reference_count);
					check_field("total_cycles", want.total_cycles, total_cycles);
					results_checked++;
					if (want.hit)
						hits_checked++;
					if (want.evicted)
						evictions_checked++;
					if (want.evicted_dirty)
						dirty_checked++;
				end
			end
			if (start && !busy) begin
				resolve_access(address, is_write, want);
				outcome_q.insert(outcome_q.size(), want);
			end
			pending = outcome_q.size();
		end
	end

endmodule

FILE: test/tb_page_frame_replacement_unit.sv
`timescale 1ns / 1ps
module tb_page_frame_replacement_unit;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 110;
	localparam logic [pfr_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [pfr_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] address;
	logic is_write;
	logic cfg_valid;
	logic cfg_ready;
	logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic done;
	logic hit;
	logic evicted;
	logic evicted_dirty;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [pfr_pkg::CNT_W-1:0] hit_count;
	logic [pfr_pkg::CNT_W-1:0] fault_count;
	logic [pfr_pkg::CNT_W-1:0] reference_count;
	logic [pfr_pkg::CYC_W-1:0] total_cycles;

	int mismatches;
	int pending;
	int results_checked;
	int hits_checked;
	int evictions_checked;
	int dirty_checked;

	int cycle_count;
	int config_count;
	logic [4:0] cur_shift;
	int unsigned cur_frames;
	logic idle_on;
	int unsigned idle_odds;
	logic [PAGE_BITS-1:0] page_pool [$];

	page_frame_replacement_unit #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.address(address),
		.is_write(is_write),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.evicted_dirty(evicted_dirty),
		.evicted_page(evicted_page),
		.hit_count(hit_count),
		.fault_count(fault_count),
		.reference_count(reference_count),
		.total_cycles(total_cycles)
	);

	pfr_checker #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) access_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.address(address),
		.is_write(is_write),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.evicted_dirty(evicted_dirty),
		.evicted_page(evicted_page),
		.hit_count(hit_count),
		.fault_count(fault_count),
		.reference_count(reference_count),
		.total_cycles(total_cycles),
		.mismatches(mismatches),
		.pending(pending),
		.results_checked(results_checked),
		.hits_checked(hits_checked),
		.evictions_checked(evictions_checked),
		.dirty_checked(dirty_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding.", pending);
			$display("[page_frame_replacement_unit] ERROR");
			$finish;
		end
	end

	task automatic send_access(input logic [31:0] addr, input logic wr);
		int unsigned gap;
		if (idle_on && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		address <= addr;
		is_write <= wr;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(
		input logic [pfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [pfr_pkg::CFG_DATA_W-1:0] data
	);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// Narrow registers get random upper data bits, which the block must drop.
	task automatic apply_config(
		input logic policy,
		input logic [4:0] frames,
		input logic [4:0] shift,
		input logic [pfr_pkg::PEN_W-1:0] load,
		input logic [pfr_pkg::PEN_W-1:0] wb
	);
		if ($urandom_range(0, 1) == 1)
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
		write_reg(pfr_pkg::REG_POLICY_MODE, {15'($urandom), policy});
		write_reg(pfr_pkg::REG_FRAMES_IN_USE, {11'($urandom), frames});
		write_reg(pfr_pkg::REG_PAGE_SHIFT, {11'($urandom), shift});
		write_reg(pfr_pkg::REG_LOAD_PENALTY, load);
		write_reg(pfr_pkg::REG_WRITEBACK_PENALTY, wb);
		cfg_valid <= 1'b0;
		cur_shift = shift;
		cur_frames = (frames == 0) ? 1 : ((frames > MAX_FRAMES) ? MAX_FRAMES : frames);
		config_count++;
	endtask

	task automatic build_pool();
		int unsigned count;
		int unsigned i;
		page_pool.delete();
		count = cur_frames + $urandom_range(1, 6);
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 15))
				0: page_pool.insert(page_pool.size(), '0);
				1: page_pool.insert(page_pool.size(), '1);
				default: page_pool.insert(page_pool.size(), PAGE_BITS'($urandom));
			endcase
		end
	endtask

	// Places a page number at the current shift and other bits at random, or at times a raw random address.
	function automatic logic [31:0] random_address();
		logic [31:0] raw;
		logic [PAGE_BITS-1:0] pg;
		logic [55:0] mask;
		logic [55:0] placed;
		raw = $urandom;
		if ($urandom_range(0, 19) == 0)
			return raw;
		if ($urandom_range(0, 6) == 0)
			pg = PAGE_BITS'($urandom);
		else
			pg = page_pool[$urandom_range(0, page_pool.size() - 1)];
		mask = 56'hFFFFFF << cur_shift;
		placed = 56'(pg) << cur_shift;
		return (raw & ~mask[31:0]) | placed[31:0];
	endfunction

	initial begin : stimulus
		int unsigned p;
		int unsigned n;
		arst_n = 1'b0;
		start = 1'b0;
		address = '0;
		is_write = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pfr_pkg::REG_POLICY_MODE;
		cfg_data = '0;
		cycle_count = 0;
		config_count = 0;
		cur_shift = pfr_pkg::RST_PAGE_SHIFT;
		cur_frames = MAX_FRAMES;
		idle_on = 1'b1;
		idle_odds = 4;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_access(32'h0000_0000, 1'b0);
		send_access(32'hFFFF_FFFF, 1'b1);
		drain();
		apply_config(pfr_pkg::POLICY_FIFO, 5'd2, 5'd12, 16'd100, 16'd500);
		send_access(32'h0000_0FFF, 1'b1);
		send_access(32'h1234_5000, 1'b0);
		send_access(32'hFFFF_F123, 1'b0);
		send_access(32'h0000_0000, 1'b0);
		drain();
		apply_config(pfr_pkg::POLICY_LRU, 5'd2, 5'd12, 16'd100, 16'd500);
		send_access(32'h1234_5ABC, 1'b0);
		send_access(32'h7777_7000, 1'b1);
		send_access(32'h1234_5000, 1'b0);
		drain();
		apply_config(pfr_pkg::POLICY_LRU, 5'd0, 5'd12, 16'hFFFF, 16'h0000);
		send_access(32'hABCD_E000, 1'b1);
		send_access(32'h0000_1000, 1'b0);
		drain();
		apply_config(pfr_pkg::POLICY_FIFO, 5'd31, 5'd0, 16'h0000, 16'hFFFF);
		send_access(32'hFFFF_FFFF, 1'b1);
		send_access(32'h00FF_FFFF, 1'b0);
		drain();
		apply_config(pfr_pkg::POLICY_LRU, 5'd16, 5'd31, 16'd1, 16'd1);
		send_access(32'h8000_0000, 1'b0);
		send_access(32'h7FFF_FFFF, 1'b1);
		drain();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_config(pfr_pkg::POLICY_FIFO, 5'd4, 5'd12, 16'd100, 16'd500);
				1: apply_config(pfr_pkg::POLICY_LRU, 5'd4, 5'd12, 16'h0000, 16'hFFFF);
				2: apply_config(pfr_pkg::POLICY_FIFO, 5'd16, 5'd8, 16'hFFFF, 16'h0000);
				3: apply_config(pfr_pkg::POLICY_LRU, 5'd16, 5'd16, 16'd1, 16'd1);
				4: apply_config(pfr_pkg::POLICY_LRU, 5'd1, 5'd12, 16'd7, 16'd9);
				5: apply_config(pfr_pkg::POLICY_FIFO, 5'd0, 5'd10, 16'd300, 16'd300);
				6: apply_config(pfr_pkg::POLICY_LRU, 5'd31, 5'd14, 16'($urandom), 16'($urandom));
				7: apply_config(pfr_pkg::POLICY_FIFO, 5'd17, 5'd0, 16'($urandom), 16'($urandom));
				8: apply_config(pfr_pkg::POLICY_LRU, 5'd3, 5'd31, 16'($urandom), 16'($urandom));
				9: apply_config(pfr_pkg::POLICY_FIFO, 5'd8, 5'd20, 16'($urandom), 16'($urandom));
				default: apply_config(1'($urandom), 5'($urandom_range(1, MAX_FRAMES)),
					5'($urandom_range(8, 16)), 16'($urandom), 16'($urandom));
			endcase
			build_pool();
			idle_on = (p != PHASES - 1);
			case ($urandom_range(0, 2))
				0: idle_odds = 3;
				1: idle_odds = 8;
				default: idle_odds = 20;
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_access(random_address(), 1'($urandom));
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d accesses over %0d register settings, both policies, frames 0 to 31.",
			results_checked, config_count);
		$display("Seen %0d hits and %0d evictions, %0d of them of modified pages.",
			hits_checked, evictions_checked, dirty_checked);
		if (mismatches == 0 && pending == 0)
			$display("[page_frame_replacement_unit] OK");
		else
			$display("[page_frame_replacement_unit] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/pfr_pkg.sv
design/pfr_front.sv
design/pfr_fifo.sv
design/pfr_table.sv
design/pfr_stats.sv
design/page_frame_replacement_unit.sv
test/pfr_checker.sv
test/tb_page_frame_replacement_unit.sv
